FILE: rtl/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
`default_nettype none

package tcce_pkg;

   localparam int COL_W     = 6;
   localparam int ROW_W     = 5;
   localparam int CODE_W    = 8;
   localparam int COLOR_W   = 8;
   localparam int REQ_W     = 2;
   localparam int CSR_IDX_W = 1;
   localparam int OP_W      = 3;
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_FG = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_BG = 1'd1;

   localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PLACE = 2'd2;

   localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
   localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
   localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
   localparam logic [CODE_W-1:0] BLANK_CODE = 8'd0;

   localparam logic KIND_GLYPH = 1'b0;
   localparam logic KIND_FILL  = 1'b1;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_NOP     = 3'd0;
   localparam op_type OP_PUT     = 3'd1;
   localparam op_type OP_PLACE   = 3'd2;
   localparam op_type OP_ERASE   = 3'd3;
   localparam op_type OP_NEWLINE = 3'd4;
   localparam op_type OP_CLEAR   = 3'd5;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [CODE_W-1:0] char_code;
   } req_item_type;

   typedef struct packed {
      logic               kind;
      logic [COL_W-1:0]   cell_column;
      logic [ROW_W-1:0]   cell_row;
      logic [CODE_W-1:0]  glyph_code;
      logic [COLOR_W-1:0] draw_color;
   } rsp_item_type;

   typedef struct packed {
      op_type            op;
      logic [CODE_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

FILE: rtl/tcce_front.sv
// Request decoder and the short command queue that feeds the execution side.
`default_nettype none

module tcce_front import tcce_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_item_type    req_data,
   input  wire back_status_type status,
   output head_type             head
);

   cmd_type                cmd;
   logic                   push;
   cmd_type                entries_ff [QDEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]        count_ff, count_in;
   logic                   full;

   always_comb begin
      cmd.code = req_data.char_code;
      unique case (req_data.req_type)
         REQ_PUT: begin
            unique case (req_data.char_code) inside
               CODE_BS, CODE_CR: cmd.op = OP_ERASE;
               CODE_LF:          cmd.op = OP_NEWLINE;
               default:          cmd.op = OP_PUT;
            endcase
         end
         REQ_CLEAR: cmd.op = OP_CLEAR;
         REQ_PLACE: cmd.op = OP_PLACE;
         default:   cmd.op = OP_NOP;
      endcase
   end

   assign full      = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign req_stall = full || status.clearing;
   assign push      = req_valid && !req_stall && (cmd.op != OP_NOP);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (status.pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !status.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && status.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tcce_back.sv
// Execution side: cursor, character store, row scan and the result register.
`default_nettype none

module tcce_back import tcce_pkg::*; #(
   parameter int COLS,
   parameter int ROWS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire head_type           head,
   input  wire logic [COLOR_W-1:0] fg_color,
   input  wire logic [COLOR_W-1:0] bg_color,
   output back_status_type         status,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_item_type            rsp_data
);

   localparam int STORE  = COLS * ROWS;
   localparam int ADDR_W = $clog2(STORE);

   localparam logic [1:0] ST_CLEAR    = 2'd0;
   localparam logic [1:0] ST_RUN      = 2'd1;
   localparam logic [1:0] ST_SCAN_RD  = 2'd2;
   localparam logic [1:0] ST_SCAN_CHK = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   logic [CODE_W-1:0]  mem [STORE];
   logic [CODE_W-1:0]  rd_data_ff;
   logic               we;
   logic [ADDR_W-1:0]  wr_addr, rd_addr, cur_base;
   logic [CODE_W-1:0]  wr_data;

   logic               out_free, col_last, row_last, pop;
   logic [ROW_W-1:0]   row_next;

   assign cur_base = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(COLS));
   assign col_last = (col_ff == COL_W'(COLS - 1));
   assign row_last = (row_ff == ROW_W'(ROWS - 1));
   assign row_next = row_last ? '0 : row_ff + 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      we           = 1'b0;
      wr_addr      = cur_base + ADDR_W'(col_ff);
      wr_data      = head.cmd.code;
      rd_addr      = cur_base + ADDR_W'(col_ff);
      pop          = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            we      = 1'b1;
            wr_addr = clr_ff;
            wr_data = BLANK_CODE;
            if (clr_ff == ADDR_W'(STORE - 1)) begin
               state_in = ST_RUN;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_RUN: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               unique case (head.cmd.op) inside
                  OP_PUT, OP_PLACE: begin
                     we                  = 1'b1;
                     rsp_valid_in        = 1'b1;
                     rsp_in.kind         = KIND_GLYPH;
                     rsp_in.cell_column  = col_ff;
                     rsp_in.cell_row     = row_ff;
                     rsp_in.glyph_code   = head.cmd.code;
                     rsp_in.draw_color   = fg_color;
                     if (head.cmd.op == OP_PUT) begin
                        if (col_last) begin
                           col_in = '0;
                           row_in = row_next;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                  end
                  OP_ERASE: begin
                     if (col_ff != '0) begin
                        col_in              = col_ff - 1'b1;
                        we                  = 1'b1;
                        wr_addr             = cur_base + ADDR_W'(col_ff - 1'b1);
                        wr_data             = BLANK_CODE;
                        rsp_valid_in        = 1'b1;
                        rsp_in.kind         = KIND_GLYPH;
                        rsp_in.cell_column  = col_ff - 1'b1;
                        rsp_in.cell_row     = row_ff;
                        rsp_in.glyph_code   = BLANK_CODE;
                        rsp_in.draw_color   = bg_color;
                     end else if (row_ff != '0) begin
                        row_in   = row_ff - 1'b1;
                        state_in = ST_SCAN_RD;
                     end
                  end
                  OP_NEWLINE: begin
                     col_in = '0;
                     row_in = row_next;
                  end
                  OP_CLEAR: begin
                     col_in              = '0;
                     row_in              = '0;
                     rsp_valid_in        = 1'b1;
                     rsp_in.kind         = KIND_FILL;
                     rsp_in.cell_column  = '0;
                     rsp_in.cell_row     = '0;
                     rsp_in.glyph_code   = BLANK_CODE;
                     rsp_in.draw_color   = bg_color;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (col_last) begin
               state_in = ST_RUN;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (rd_data_ff == BLANK_CODE) begin
               state_in = ST_RUN;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign status.pop      = pop;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/text_console_cursor_engine_top.sv
// Top level of the text console cursor engine.
//
// Requests arrive on the req_ channel (valid/stall) as a request type and a
// character byte. Each transfer yields at most one result on the rsp_ channel:
// a glyph draw at one cell or a fill of the whole screen. Foreground and
// background colors are set through the csr_ write port; the user is to write
// them only while the block is idle; the block does not enforce this. A decoder
// and a two-entry command queue sit in front of the execution side. A request
// passes through a queue entry and any result through the result register.
// Plain characters, newlines and clears execute as soon as they reach the queue
// head, so the block sustains one transfer per cycle while the receiver does not
// stall and no scan runs. An erase at column 0 that moves up a row scans that row
// in the character store in a read state and a check state per examined cell,
// paced by the registered read port of the store. After reset the store is swept
// to zero, one cell per cycle; req_stall stays high during the sweep. When the
// receiver stalls, the result register holds its value and the queue absorbs
// up to two more requests before req_stall rises.
`default_nettype none

module text_console_cursor_engine_top import tcce_pkg::*; #(
   parameter int COLS = 40,
   parameter int ROWS = 25
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_item_type         req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_item_type              rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0]   csr_wdata
);

   logic [COLOR_W-1:0] fg_color_ff;
   logic [COLOR_W-1:0] bg_color_ff;
   head_type           head;
   back_status_type    status;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff <= '0;
         bg_color_ff <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_IDX_FG) begin
            fg_color_ff <= csr_wdata;
         end
         if (csr_index == CSR_IDX_BG) begin
            bg_color_ff <= csr_wdata;
         end
      end
   end

   tcce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (status),
      .head      (head)
   );

   tcce_back #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .fg_color  (fg_color_ff),
      .bg_color  (bg_color_ff),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/tcce_checker.sv
// Port-level assertions for the text console cursor engine and their binding.
`default_nettype none

module tcce_checker import tcce_pkg::*; #(
   parameter int COLS,
   parameter int ROWS
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result offered right after reset.");

   a_reset_sweep: assert property (@(posedge clock) reset |=> req_stall)
      else $error("Requests taken during the store sweep.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed or dropped.");

   a_fill_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_FILL) |->
         (rsp_data.cell_column == '0) && (rsp_data.cell_row == '0) &&
         (rsp_data.glyph_code == BLANK_CODE))
      else $error("Screen fill carries a cell or glyph.");

   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_GLYPH) |->
         (rsp_data.cell_column < COL_W'(COLS)) && (rsp_data.cell_row < ROW_W'(ROWS)))
      else $error("Glyph transfer outside the screen.");

endmodule

bind text_console_cursor_engine_top tcce_checker #(
   .COLS (COLS),
   .ROWS (ROWS)
) u_tcce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
